// ----- src/qph_pkg.sv -----
package qph_pkg;

  localparam int DefTableSize  = 16;
  localparam int DefProbeLimit = 16;

  localparam int OpW      = 2;
  localparam int KeyW     = 31;
  localparam int ValueW   = 31;
  localparam int SlotIdxW = 4;

  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpSearch = 2'd1,
    OpDelete = 2'd2
  } op_e;

endpackage

// ----- src/qph_ram.sv -----
module qph_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/qph_key_mod.sv -----
module qph_key_mod import qph_pkg::*; #(
  parameter int TableSize = DefTableSize
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [KeyW-1:0]              key_i,
  output logic                         done_o,
  output logic [$clog2(TableSize)-1:0] rem_o
);

  localparam int SlotW   = $clog2(TableSize);
  localparam int Nibbles = (KeyW + 3) / 4;
  localparam int PadW    = Nibbles * 4;
  localparam int CntW    = $clog2(Nibbles);
  localparam int XW      = SlotW + 4;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PadW-1:0] sh_q, sh_d;
  logic [SlotW-1:0] rem_q, rem_d;
  logic [XW-1:0]   x;

  always_comb begin
    x = {rem_q, sh_q[PadW-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (x >= (XW'(TableSize) << k)) begin
        x = x - (XW'(TableSize) << k);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Nibbles - 1);
      sh_d   = PadW'(key_i);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = x[SlotW-1:0];
      sh_d  = sh_q << 4;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/quadratic_probe_hash_table.sv -----
// Flow: a request reduces the key modulo TABLE_SIZE, 4 key bits a cycle, then probes
//   n slots, n = probes examined (1 .. PROBE_LIMIT+1), before the result is registered.
// Requests: a new request is taken only once the result is registered; the probe
//   walk reads one slot a cycle.
// Reset: a clearing pass over all TABLE_SIZE slots empties every slot; no request is
//   taken until it ends.
module quadratic_probe_hash_table import qph_pkg::*; #(
  parameter int TableSize  = DefTableSize,
  parameter int ProbeLimit = DefProbeLimit
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OpW-1:0]      opcode_i,
  input  logic [KeyW-1:0]     key_i,
  input  logic [ValueW-1:0]   value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                success_o,
  output logic [SlotIdxW-1:0] slot_index_o
);

  localparam int SlotW = $clog2(TableSize);
  localparam int StepW = $clog2(ProbeLimit + 1);
  localparam int EntW  = KeyW + 1;

  typedef enum logic [4:0] {
    StClear  = 5'b00001,
    StIdle   = 5'b00010,
    StHash   = 5'b00100,
    StProbe  = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SlotW-1:0] clr_q, clr_d;
  op_e              op_q;
  logic [KeyW-1:0]  key_q;
  logic [ValueW-1:0] val_q;

  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] delta_q, delta_d;
  logic [StepW-1:0] iss_q, iss_d;
  logic             issuing_q, issuing_d;
  logic             chk_valid_q, chk_valid_d;
  logic [SlotW-1:0] chk_slot_q, chk_slot_d;
  logic             chk_last_q, chk_last_d;
  logic             found_q, found_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;

  logic                out_valid_q, out_valid_d;
  logic                success_q, success_d;
  logic [SlotIdxW-1:0] sidx_q, sidx_d;

  logic             in_acc;
  logic             mod_done;
  logic [SlotW-1:0] mod_rem;

  logic             ent_we;
  logic [SlotW-1:0] ent_waddr;
  logic [EntW-1:0]  ent_wdata;
  logic             ent_re;
  logic [EntW-1:0]  ent_rdata;
  logic             val_we;

  logic             occ;
  logic             hit;
  logic [SlotW:0]   ssum;
  logic [SlotW:0]   dsum;
  logic [SlotW-1:0] slot_nx;
  logic [SlotW-1:0] delta_nx;
  logic [SlotW+SlotIdxW-1:0] res_ext;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  qph_key_mod #(
    .TableSize(TableSize)
  ) u_key_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc),
    .key_i  (key_i),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  qph_ram #(
    .Width(EntW),
    .Depth(TableSize)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (ent_re),
    .raddr_i(slot_q),
    .rdata_o(ent_rdata)
  );

  qph_ram #(
    .Width(ValueW),
    .Depth(TableSize)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(res_slot_q),
    .wdata_i(val_q),
    .re_i   (1'b0),
    .raddr_i(res_slot_q),
    .rdata_o()
  );

  assign occ = ent_rdata[KeyW];
  assign hit = (op_q == OpInsert) ? !occ : (occ && (ent_rdata[KeyW-1:0] == key_q));

  always_comb begin
    ssum    = {1'b0, slot_q} + {1'b0, delta_q};
    slot_nx = ssum[SlotW-1:0];
    if (ssum >= (SlotW+1)'(TableSize)) begin
      slot_nx = SlotW'(ssum - (SlotW+1)'(TableSize));
    end
    dsum     = {1'b0, delta_q} + (SlotW+1)'(2);
    delta_nx = dsum[SlotW-1:0];
    if (dsum >= (SlotW+1)'(TableSize)) begin
      delta_nx = SlotW'(dsum - (SlotW+1)'(TableSize));
    end
  end

  assign res_ext = {{SlotIdxW{1'b0}}, res_slot_q};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    delta_d     = delta_q;
    iss_d       = iss_q;
    issuing_d   = issuing_q;
    chk_valid_d = 1'b0;
    chk_slot_d  = chk_slot_q;
    chk_last_d  = chk_last_q;
    found_d     = found_q;
    res_slot_d  = res_slot_q;
    out_valid_d = out_valid_q;
    success_d   = success_q;
    sidx_d      = sidx_q;
    ent_we      = 1'b0;
    ent_waddr   = res_slot_q;
    ent_wdata   = {1'b0, key_q};
    ent_re      = 1'b0;
    val_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == SlotW'(TableSize - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          state_d = StHash;
        end
      end
      StHash: begin
        if (mod_done) begin
          slot_d    = mod_rem;
          delta_d   = SlotW'(1);
          iss_d     = '0;
          issuing_d = 1'b1;
          found_d   = 1'b0;
          if (op_q inside {OpInsert, OpSearch, OpDelete}) begin
            state_d = StProbe;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StProbe: begin
        if (issuing_q) begin
          ent_re      = 1'b1;
          chk_valid_d = 1'b1;
          chk_slot_d  = slot_q;
          chk_last_d  = (iss_q == StepW'(ProbeLimit));
          slot_d      = slot_nx;
          delta_d     = delta_nx;
          iss_d       = iss_q + 1'b1;
          if (iss_q == StepW'(ProbeLimit)) begin
            issuing_d = 1'b0;
          end
        end
        if (chk_valid_q) begin
          if (hit) begin
            found_d    = 1'b1;
            res_slot_d = chk_slot_q;
            issuing_d  = 1'b0;
            state_d    = StFinish;
          end else if (chk_last_q) begin
            state_d = StFinish;
          end
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          success_d   = found_q;
          sidx_d      = found_q ? res_ext[SlotIdxW-1:0] : '0;
          if (found_q && (op_q == OpInsert)) begin
            ent_we    = 1'b1;
            ent_wdata = {1'b1, key_q};
            val_we    = 1'b1;
          end else if (found_q && (op_q == OpDelete)) begin
            ent_we    = 1'b1;
            ent_wdata = {1'b0, key_q};
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      issuing_q   <= 1'b0;
      chk_valid_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      issuing_q   <= issuing_d;
      chk_valid_q <= chk_valid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_e'(opcode_i);
      key_q <= key_i;
      val_q <= value_i;
    end
    slot_q     <= slot_d;
    delta_q    <= delta_d;
    iss_q      <= iss_d;
    chk_slot_q <= chk_slot_d;
    chk_last_q <= chk_last_d;
    res_slot_q <= res_slot_d;
    success_q  <= success_d;
    sidx_q     <= sidx_d;
  end

  assign out_valid_o  = out_valid_q;
  assign success_o    = success_q;
  assign slot_index_o = sidx_q;

`ifndef SYNTHESIS
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFinish))
    else $error("result raised outside finish");

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !success_q) |-> (sidx_q == '0))
    else $error("failed request carries a nonzero slot");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> (state_q == StClear || state_q == StFinish))
    else $error("entry write outside clear or finish");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StProbe && issuing_q) |-> ({1'b0, slot_q} < (SlotW+1)'(TableSize)))
    else $error("probe slot out of range");
`endif

endmodule
